/* sv/bdl_pkg.sv */
// Shared types and constants for the bracket decorator lexer.
`timescale 1ns / 1ps
`default_nettype none

package bdl_pkg;

    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CLASS_W = 2;
    localparam int ERR_W   = 3;
    localparam int COUNT_W = 4;
    localparam int TDATA_W = 16;

    localparam logic [COUNT_W-1:0] KEYWORD_LEN = 4'd11;

    // Keyword text, padded with zeros so positions past the word never match
    localparam logic [CHAR_W-1:0] KEY_TEXT [16] = '{
        8'h4C, 8'h6F, 8'h63, 8'h61, 8'h6C, 8'h49, 8'h6D, 8'h70,
        8'h6F, 8'h72, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [KIND_W-1:0] KIND_NAME_CHAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NAME_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VERDICT   = 2'd2;

    localparam logic [CLASS_W-1:0] CLASS_DECORATOR = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_CODE      = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_BLANK     = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_ILLEGAL     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BRACKET     = 3'd2;
    localparam logic [ERR_W-1:0] ERR_PAREN       = 3'd3;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN_DEC = 3'd4;
    localparam logic [ERR_W-1:0] ERR_UNCLOSED    = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAR_W-1:0]  name_char;
        logic [CLASS_W-1:0] line_class;
        logic [ERR_W-1:0]   error;
        logic               last;
    } result_t;

    // Results of one accepted character, in output order
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

`default_nettype wire

/* sv/bdl_lexer.sv */
// Parse state registers and the per-character lexing step.
`timescale 1ns / 1ps
`default_nettype none

module bdl_lexer
    import bdl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_accept,
    input  wire logic [CHAR_W-1:0] in_ch,
    input  wire logic              in_line_end,
    output push_t                  push
);

    localparam logic [2:0] PH_OPEN    = 3'd0;
    localparam logic [2:0] PH_KEYWORD = 3'd1;
    localparam logic [2:0] PH_NAMES   = 3'd2;
    localparam logic [2:0] PH_CLOSED  = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    logic [2:0]         phase_reg, phase_next;
    logic [COUNT_W-1:0] kcnt_reg, kcnt_next;
    logic               kmatch_reg, kmatch_next;
    logic               started_reg, started_next;
    logic [CLASS_W-1:0] class_reg, class_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic               stopped_reg, stopped_next;

    logic    space;
    logic    char_res;
    result_t res_char;
    result_t res_verdict;

    assign space = (in_ch == 8'h20) || (in_ch >= 8'h09 && in_ch <= 8'h0D);

    always_comb begin
        phase_next   = phase_reg;
        kcnt_next    = kcnt_reg;
        kmatch_next  = kmatch_reg;
        started_next = started_reg;
        class_next   = class_reg;
        err_next     = err_reg;
        stopped_next = stopped_reg;
        char_res     = 1'b0;
        res_char     = '0;

        if (!stopped_reg) begin
            if (in_ch == 8'h00) begin
                stopped_next = 1'b1;
            end else if (space && (phase_reg == PH_OPEN || phase_reg == PH_DONE ||
                                   (phase_reg == PH_NAMES && !started_reg))) begin
                // skipped white space
            end else if (phase_reg == PH_DONE) begin
                err_next     = ERR_ILLEGAL;
                stopped_next = 1'b1;
            end else if (in_ch == 8'h5B) begin
                if (phase_reg == PH_OPEN) begin
                    phase_next = PH_KEYWORD;
                    class_next = CLASS_DECORATOR;
                end else begin
                    err_next     = ERR_BRACKET;
                    stopped_next = 1'b1;
                end
            end else if (in_ch == 8'h5D) begin
                if (phase_reg == PH_CLOSED) begin
                    phase_next = PH_DONE;
                end else begin
                    err_next     = ERR_BRACKET;
                    stopped_next = 1'b1;
                end
            end else if (in_ch == 8'h28) begin
                if (phase_reg == PH_KEYWORD) begin
                    phase_next = PH_NAMES;
                    if (!(kcnt_reg == KEYWORD_LEN && kmatch_reg)) begin
                        err_next     = ERR_UNKNOWN_DEC;
                        stopped_next = 1'b1;
                    end
                end else begin
                    err_next     = ERR_PAREN;
                    stopped_next = 1'b1;
                end
            end else if (in_ch == 8'h29) begin
                if (phase_reg == PH_NAMES) begin
                    char_res       = started_reg;
                    res_char.kind  = KIND_NAME_END;
                    started_next   = 1'b0;
                    phase_next     = PH_CLOSED;
                end else begin
                    err_next     = ERR_PAREN;
                    stopped_next = 1'b1;
                end
            end else if (phase_reg == PH_OPEN) begin
                class_next   = CLASS_CODE;
                stopped_next = 1'b1;
            end else if (phase_reg == PH_KEYWORD) begin
                if (kcnt_reg >= KEYWORD_LEN) begin
                    err_next     = ERR_UNKNOWN_DEC;
                    stopped_next = 1'b1;
                end else begin
                    if (KEY_TEXT[kcnt_reg] != in_ch) begin
                        kmatch_next = 1'b0;
                    end
                    kcnt_next = kcnt_reg + 1'b1;
                end
            end else if (phase_reg == PH_NAMES) begin
                if (in_ch == 8'h2C) begin
                    if (!started_reg) begin
                        err_next     = ERR_ILLEGAL;
                        stopped_next = 1'b1;
                    end else begin
                        char_res      = 1'b1;
                        res_char.kind = KIND_NAME_END;
                        started_next  = 1'b0;
                    end
                end else begin
                    char_res           = 1'b1;
                    res_char.kind      = KIND_NAME_CHAR;
                    res_char.name_char = in_ch;
                    started_next       = 1'b1;
                end
            end else begin
                err_next     = ERR_UNCLOSED;
                stopped_next = 1'b1;
            end
        end

        // Verdict carries the class and error after this character
        res_verdict            = '0;
        res_verdict.kind       = KIND_VERDICT;
        res_verdict.line_class = class_next;
        res_verdict.error      = err_next;
        res_verdict.last       = 1'b1;

        push = '0;
        if (char_res && in_line_end) begin
            push.cnt = 2'd2;
            push.r0  = res_char;
            push.r1  = res_verdict;
        end else if (char_res) begin
            push.cnt     = 2'd1;
            push.r0      = res_char;
            push.r0.last = 1'b1;
        end else if (in_line_end) begin
            push.cnt = 2'd1;
            push.r0  = res_verdict;
        end

        if (in_line_end) begin
            phase_next   = PH_OPEN;
            kcnt_next    = '0;
            kmatch_next  = 1'b1;
            started_next = 1'b0;
            class_next   = CLASS_BLANK;
            err_next     = ERR_NONE;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_OPEN;
            kcnt_reg    <= '0;
            kmatch_reg  <= 1'b1;
            started_reg <= 1'b0;
            class_reg   <= CLASS_BLANK;
            err_reg     <= ERR_NONE;
            stopped_reg <= 1'b0;
        end else if (in_accept) begin
            phase_reg   <= phase_next;
            kcnt_reg    <= kcnt_next;
            kmatch_reg  <= kmatch_next;
            started_reg <= started_next;
            class_reg   <= class_next;
            err_reg     <= err_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

`default_nettype wire

/* sv/bdl_outq.sv */
// Four-entry result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps
`default_nettype none

module bdl_outq
    import bdl_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push_en,
    input  wire push_t push,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_res
);

    result_t    slot_reg [4];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_in;
    logic       pop;

    assign n_in      = push_en ? push.cnt : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 3'd0);
    assign out_res   = slot_reg[rptr_reg];
    // Keep room for the worst case of two results per transfer
    assign room      = (count_reg <= 3'd2);
    assign count_next = count_reg + {1'b0, n_in} - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (n_in != 2'd0) begin
            slot_reg[wptr_reg] <= push.r0;
        end
        if (n_in == 2'd2) begin
            slot_reg[wptr_reg + 2'd1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_reg + n_in;
            rptr_reg  <= rptr_reg + {1'b0, pop};
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/bracket_decorator_lexer.sv */
// Top level of the bracket decorator lexer: stream ports, lexer and result queue.
`timescale 1ns / 1ps
`default_nettype none

// Lexes a source line, one byte per transfer, against [LocalImport(name, ...)].
// A byte is taken every cycle as long as the four-entry result queue has two
// free slots; the lexing step is combinational logic on the parse registers.
// Each byte yields zero, one or two results (name byte or end of name, and the
// line verdict on the tlast byte); results leave one per cycle while m_tready
// is high, so the input runs at one byte per cycle unless names and verdicts pile
// up faster than the output side takes them. Results are registered in the
// result queue before they reach the output.
module bracket_decorator_lexer
    import bdl_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] ch
    input  wire logic               s_tlast,   // line_end
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [7:0] name_char, [9:8] line_class,
                                               // [12:10] error, [15:13] zero
    output logic [KIND_W-1:0]       m_tuser,   // kind
    output logic                    m_tlast    // last
);

    logic    s_accept;
    push_t   push;
    result_t res;

    assign s_accept = s_tvalid && s_tready;

    bdl_lexer u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (s_accept),
        .in_ch       (s_tdata),
        .in_line_end (s_tlast),
        .push        (push)
    );

    bdl_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (s_accept),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {3'b000, res.error, res.line_class, res.name_char};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

/* sv/bdl_checker.sv */
// Port-level checks for the bracket decorator lexer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bdl_checker
    import bdl_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [KIND_W-1:0]  m_tuser,
    input wire logic               m_tlast
);

    // Queue is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // A verdict always closes the results of its byte
    a_verdict_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_VERDICT |-> m_tlast)
        else $error("verdict without tlast");

    // Name results carry no class or error, and error codes stay in range
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:13] == 3'b000
                     && (m_tuser == KIND_VERDICT || m_tdata[12:8] == 5'd0)
                     && m_tdata[12:10] <= ERR_UNCLOSED)
        else $error("bad result fields");

    // End-of-name carries no byte
    a_name_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_NAME_END |-> m_tdata[7:0] == 8'h00)
        else $error("end of name with data");

endmodule

bind bracket_decorator_lexer bdl_checker u_bdl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
